// File: hw/rtl/mer_pkg.sv
// Shared types of the midpoint ellipse rasterizer: operation and region codes.
`default_nettype none

package mer_pkg;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic {
      REGION_ONE = 1'b0,
      REGION_TWO = 1'b1
   } region_type;

endpackage

`default_nettype wire

// File: hw/rtl/mer_req_if.sv
// Request channel of the midpoint ellipse rasterizer: load and step items.
`default_nettype none

interface mer_req_if #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 11
);
   logic                   valid;
   logic                   ready;
   mer_pkg::op_type        op;
   logic [COORD_BITS-1:0]  center_x;
   logic [COORD_BITS-1:0]  center_y;
   logic [RADIUS_BITS-1:0] radius_x;
   logic [RADIUS_BITS-1:0] radius_y;

   modport source (output valid, output op, output center_x, output center_y,
                   output radius_x, output radius_y, input ready);
   modport sink (input valid, input op, input center_x, input center_y,
                 input radius_x, input radius_y, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/mer_rsp_if.sv
// Response channel of the midpoint ellipse rasterizer: one point set per step item.
`default_nettype none

interface mer_rsp_if #(
   parameter int COORD_BITS = 11
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS+1:0] right_x;
   logic signed [COORD_BITS+1:0] left_x;
   logic signed [COORD_BITS+1:0] bottom_y;
   logic signed [COORD_BITS+1:0] top_y;
   mer_pkg::region_type          region;
   logic                         last;

   modport source (output valid, output right_x, output left_x, output bottom_y,
                   output top_y, output region, output last, input ready);
   modport sink (input valid, input right_x, input left_x, input bottom_y,
                 input top_y, input region, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/midpoint_ellipse_rasterizer.sv
// Midpoint ellipse rasterizer: a sequencer around one shared signed multiplier.
//
// Usage. Items arrive on req_if with a valid/ready handshake. A load item
// (op = OP_LOAD) gives the centre and both radii and starts a new ellipse; it
// returns nothing. Each step item (op = OP_STEP) returns one set of four
// symmetric points on rsp_if, with the region it belongs to and a last flag
// on the final set. Steps sent while no ellipse is active are dropped.
//
// Timing. req_if.ready is high only while the sequencer is idle. A load item
// occupies the block while the single multiplier forms three products, a step
// item while it forms two (ry^2*x and rx^2*y), and the one step that moves
// from region one to region two while it forms five more. Each product is
// issued in its own cycle and registered before use.
//
// Reset clears the sequencer, leaves no ellipse loaded and empties the output
// register. When the receiver stalls, a finished point set waits in the output
// register; the next item is still accepted and worked on, and its result is
// held until the output register is free.
`default_nettype none

module midpoint_ellipse_rasterizer #(
   parameter int RADIUS_BITS = 10,
   parameter int COORD_BITS  = 11
) (
   input  wire        clock,
   input  wire        reset,
   mer_req_if.sink    req_if,
   mer_rsp_if.source  rsp_if
);

   // Output coordinate, offset, multiplier operand and decision widths.
   localparam int OW = COORD_BITS + 2;
   localparam int FW = RADIUS_BITS + 2;
   localparam int MW = 2 * RADIUS_BITS + 6;
   localparam int DW = 4 * RADIUS_BITS + 8;
   localparam int SW = ((OW > FW) ? OW : FW) + 1;
   localparam int QW = 2 * RADIUS_BITS;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_L_RX2,
      ST_L_RY2,
      ST_L_T,
      ST_L_D,
      ST_S_PA,
      ST_S_PB,
      ST_S_UPD,
      ST_T_TX,
      ST_T_A,
      ST_T_YM,
      ST_T_B,
      ST_T_C,
      ST_T_D,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_ONE,
      PH_TWO,
      PH_DONE
   } phase_type;

   state_type state_ff;
   phase_type phase_ff;

   logic [COORD_BITS-1:0]  cx_ff;
   logic [COORD_BITS-1:0]  cy_ff;
   logic [RADIUS_BITS-1:0] rx_ff;
   logic [RADIUS_BITS-1:0] ry_ff;
   logic [QW-1:0]          rx2_ff;
   logic [QW-1:0]          ry2_ff;
   logic signed [FW-1:0]   x_ff;
   logic signed [FW-1:0]   y_ff;
   logic signed [DW-1:0]   dec_ff;
   logic signed [DW-1:0]   prod_ff;
   logic signed [DW-1:0]   acc_ff;
   logic                   br_ff;

   logic signed [OW-1:0]   pend_right_ff;
   logic signed [OW-1:0]   pend_left_ff;
   logic signed [OW-1:0]   pend_bottom_ff;
   logic signed [OW-1:0]   pend_top_ff;
   mer_pkg::region_type    pend_region_ff;
   logic                   pend_last_ff;

   logic                   rsp_valid_ff;
   logic signed [OW-1:0]   rsp_right_ff;
   logic signed [OW-1:0]   rsp_left_ff;
   logic signed [OW-1:0]   rsp_bottom_ff;
   logic signed [OW-1:0]   rsp_top_ff;
   mer_pkg::region_type    rsp_region_ff;
   logic                   rsp_last_ff;

   // The shared multiplier. Its operands are chosen by the sequencer state and
   // its product is always registered in prod_ff.
   logic signed [MW-1:0]   mul_a;
   logic signed [MW-1:0]   mul_b;
   logic signed [2*MW-1:0] mul_full;

   logic signed [FW:0]     tx;
   logic signed [FW:0]     ym;
   logic signed [DW-1:0]   rx2_d;
   logic signed [DW-1:0]   ry2_d;

   assign tx    = (FW + 1)'(x_ff) + (FW + 1)'(x_ff) + (FW + 1)'(1);
   assign ym    = (FW + 1)'(y_ff) - (FW + 1)'(1);
   assign rx2_d = DW'(rx2_ff);
   assign ry2_d = DW'(ry2_ff);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_L_RX2: begin
            mul_a = MW'(rx_ff);
            mul_b = MW'(rx_ff);
         end
         ST_L_RY2: begin
            mul_a = MW'(ry_ff);
            mul_b = MW'(ry_ff);
         end
         ST_L_T: begin
            mul_a = MW'(rx2_ff);
            mul_b = MW'(ry_ff);
         end
         ST_S_PA: begin
            mul_a = MW'(ry2_ff);
            mul_b = MW'(x_ff);
         end
         ST_S_PB: begin
            mul_a = MW'(rx2_ff);
            mul_b = MW'(y_ff);
         end
         ST_T_TX: begin
            mul_a = MW'(tx);
            mul_b = MW'(tx);
         end
         ST_T_A: begin
            mul_a = MW'(ry2_ff);
            mul_b = prod_ff[MW-1:0];
         end
         ST_T_YM: begin
            mul_a = MW'(ym);
            mul_b = MW'(ym);
         end
         ST_T_B: begin
            mul_a = MW'(rx2_ff);
            mul_b = prod_ff[MW-1:0];
         end
         ST_T_C: begin
            mul_a = MW'(rx2_ff);
            mul_b = MW'(ry2_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;

   // Point set of the current offsets, wrapped to the output width.
   logic signed [SW-1:0] sum_right;
   logic signed [SW-1:0] sum_left;
   logic signed [SW-1:0] sum_bottom;
   logic signed [SW-1:0] sum_top;

   assign sum_right  = SW'(cx_ff) + SW'(x_ff);
   assign sum_left   = SW'(cx_ff) - SW'(x_ff);
   assign sum_bottom = SW'(cy_ff) + SW'(y_ff);
   assign sum_top    = SW'(cy_ff) - SW'(y_ff);

   // Offsets after one step. In region one x always advances and y follows
   // when the decision is not negative; in region two y always falls and x
   // follows when the decision is not positive.
   logic                 dec_neg;
   logic                 dec_pos;
   logic                 step_br;
   logic signed [FW-1:0] x_step;
   logic signed [FW-1:0] y_step;

   assign dec_neg = dec_ff[DW-1];
   assign dec_pos = !dec_ff[DW-1] && (dec_ff != '0);

   always_comb begin
      if (phase_ff == PH_TWO) begin
         step_br = dec_pos;
         y_step  = y_ff - FW'(1);
         x_step  = dec_pos ? x_ff : x_ff + FW'(1);
      end else begin
         step_br = !dec_neg;
         x_step  = x_ff + FW'(1);
         y_step  = dec_neg ? y_ff : y_ff - FW'(1);
      end
   end

   // Decision update from pa (ry^2*x, held in acc_ff) and pb (rx^2*y, in
   // prod_ff), both taken at the new offsets.
   logic signed [DW-1:0] pa8;
   logic signed [DW-1:0] pb8;
   logic signed [DW-1:0] upd_one;
   logic signed [DW-1:0] upd_two;
   logic                 one_holds;
   logic                 y_neg;

   assign pa8   = acc_ff <<< 3;
   assign pb8   = prod_ff <<< 3;
   assign y_neg = y_ff[FW-1];

   always_comb begin
      if (br_ff) begin
         upd_one = dec_ff + pa8 - pb8 + (ry2_d <<< 2);
         upd_two = dec_ff - pb8 + (rx2_d <<< 2);
      end else begin
         upd_one = dec_ff + pa8 + (ry2_d <<< 2);
         upd_two = dec_ff + pa8 - pb8 + (rx2_d <<< 2);
      end
   end

   assign one_holds = (acc_ff <= prod_ff) && !y_neg;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // In ST_OUT the output register is refilled below instead.
         if (rsp_valid_ff && rsp_if.ready && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_if.valid) begin
                  if (req_if.op == mer_pkg::OP_LOAD) begin
                     cx_ff    <= req_if.center_x;
                     cy_ff    <= req_if.center_y;
                     rx_ff    <= req_if.radius_x;
                     ry_ff    <= req_if.radius_y;
                     x_ff     <= '0;
                     y_ff     <= FW'(req_if.radius_y);
                     state_ff <= ST_L_RX2;
                  end else if (phase_ff == PH_ONE || phase_ff == PH_TWO) begin
                     pend_right_ff  <= sum_right[OW-1:0];
                     pend_left_ff   <= sum_left[OW-1:0];
                     pend_bottom_ff <= sum_bottom[OW-1:0];
                     pend_top_ff    <= sum_top[OW-1:0];
                     pend_region_ff <= (phase_ff == PH_TWO) ? mer_pkg::REGION_TWO
                                                            : mer_pkg::REGION_ONE;
                     x_ff           <= x_step;
                     y_ff           <= y_step;
                     br_ff          <= step_br;
                     state_ff       <= ST_S_PA;
                  end
               end
            end
            ST_L_RX2: begin
               state_ff <= ST_L_RY2;
            end
            ST_L_RY2: begin
               rx2_ff   <= prod_ff[QW-1:0];
               state_ff <= ST_L_T;
            end
            ST_L_T: begin
               ry2_ff   <= prod_ff[QW-1:0];
               state_ff <= ST_L_D;
            end
            ST_L_D: begin
               // 4ry^2 - 4rx^2*ry + rx^2
               dec_ff   <= (ry2_d <<< 2) - (prod_ff <<< 2) + rx2_d;
               phase_ff <= PH_ONE;
               state_ff <= ST_IDLE;
            end
            ST_S_PA: begin
               state_ff <= ST_S_PB;
            end
            ST_S_PB: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_S_UPD;
            end
            ST_S_UPD: begin
               if (phase_ff == PH_TWO) begin
                  dec_ff       <= upd_two;
                  pend_last_ff <= y_neg;
                  if (y_neg) begin
                     phase_ff <= PH_DONE;
                  end
                  state_ff <= ST_OUT;
               end else begin
                  dec_ff <= upd_one;
                  if (one_holds) begin
                     pend_last_ff <= 1'b0;
                     state_ff     <= ST_OUT;
                  end else if (y_neg) begin
                     pend_last_ff <= 1'b1;
                     phase_ff     <= PH_DONE;
                     state_ff     <= ST_OUT;
                  end else begin
                     pend_last_ff <= 1'b0;
                     state_ff     <= ST_T_TX;
                  end
               end
            end
            // Region two start: ry^2(2x+1)^2 + 4rx^2(y-1)^2 - 4rx^2*ry^2.
            ST_T_TX: begin
               state_ff <= ST_T_A;
            end
            ST_T_A: begin
               state_ff <= ST_T_YM;
            end
            ST_T_YM: begin
               acc_ff   <= prod_ff;
               state_ff <= ST_T_B;
            end
            ST_T_B: begin
               state_ff <= ST_T_C;
            end
            ST_T_C: begin
               acc_ff   <= acc_ff + (prod_ff <<< 2);
               state_ff <= ST_T_D;
            end
            ST_T_D: begin
               dec_ff   <= acc_ff - (prod_ff <<< 2);
               phase_ff <= PH_TWO;
               state_ff <= ST_OUT;
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp_if.ready) begin
                  rsp_right_ff  <= pend_right_ff;
                  rsp_left_ff   <= pend_left_ff;
                  rsp_bottom_ff <= pend_bottom_ff;
                  rsp_top_ff    <= pend_top_ff;
                  rsp_region_ff <= pend_region_ff;
                  rsp_last_ff   <= pend_last_ff;
                  rsp_valid_ff  <= 1'b1;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
      prod_ff <= mul_full[DW-1:0];
   end

   assign req_if.ready    = (state_ff == ST_IDLE);
   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.right_x  = rsp_right_ff;
   assign rsp_if.left_x   = rsp_left_ff;
   assign rsp_if.bottom_y = rsp_bottom_ff;
   assign rsp_if.top_y    = rsp_top_ff;
   assign rsp_if.region   = rsp_region_ff;
   assign rsp_if.last     = rsp_last_ff;

endmodule

`default_nettype wire
